[design/mtcc_pkg.sv]
package mtcc_pkg;

	// operation codes
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_SET_TIME = 2'd1;
	localparam logic [1:0] OP_SET_DATE = 2'd2;

	localparam logic [5:0]  MINUTE_LAST = 6'd59;
	localparam logic [4:0]  HOUR_LAST   = 5'd23;
	localparam logic [3:0]  MONTH_LAST  = 4'd12;
	localparam logic [2:0]  WEEKDAY_LAST = 3'd6;
	localparam logic [7:0]  HOUR_LIMIT  = 8'd24;
	localparam logic [7:0]  MINUTE_LIMIT = 8'd60;
	localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;

	localparam logic [5:0]  MINUTE_RESET  = 6'd0;
	localparam logic [4:0]  HOUR_RESET    = 5'd0;
	localparam logic [4:0]  DAY_RESET     = 5'd1;
	localparam logic [3:0]  MONTH_RESET   = 4'd1;
	localparam logic [15:0] YEAR_RESET    = 16'd2001;
	localparam logic [2:0]  WEEKDAY_RESET = 3'd0;

	// month length, invalid months have length 0
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	typedef struct packed {
		logic [1:0]  operation;
		logic        trip_running;
		logic [7:0]  hour_value;
		logic [7:0]  minute_value;
		logic [4:0]  day_value;
		logic [3:0]  month_value;
		logic [15:0] year_value;
	} req_t;

	typedef struct packed {
		logic [5:0]  minute_now;
		logic [4:0]  hour_now;
		logic [4:0]  day_now;
		logic [3:0]  month_now;
		logic [15:0] year_now;
		logic [2:0]  weekday_now;
		logic        accepted;
		logic        clear_trip;
	} rsp_t;

	typedef struct packed {
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [2:0]  weekday;
	} cal_t;

	function automatic logic [4:0] days_in(input logic [3:0] month, input logic [15:0] year);
		if (month == MONTH_FEB && year[1:0] == 2'b00)
			return FEB_LEAP_DAYS;
		return MONTH_LEN[month];
	endfunction

endpackage

[design/mtcc_chan_if.sv]
interface mtcc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/mtcc_timekeeper.sv]
module mtcc_timekeeper
	import mtcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t item,
	output rsp_t result
);

	cal_t       cal_q;
	cal_t       cal_d;
	logic       acc;
	logic       clr;
	logic [4:0] dim;

	assign dim = days_in(cal_q.month, cal_q.year);

	always_comb begin
		cal_d = cal_q;
		acc   = 1'b1;
		clr   = 1'b0;
		case (item.operation)
			OP_TICK: begin
				if (cal_q.minute < MINUTE_LAST) begin
					cal_d.minute = cal_q.minute + 6'd1;
				end else begin
					cal_d.minute = '0;
					if (cal_q.hour < HOUR_LAST) begin
						cal_d.hour = cal_q.hour + 5'd1;
					end else begin
						// day rollover
						cal_d.hour = '0;
						if (cal_q.day < dim) begin
							cal_d.day = cal_q.day + 5'd1;
						end else begin
							cal_d.day = DAY_RESET;
							if (cal_q.month < MONTH_LAST) begin
								cal_d.month = cal_q.month + 4'd1;
							end else begin
								cal_d.month = MONTH_RESET;
								cal_d.year  = cal_q.year + 16'd1;
							end
						end
						if (cal_q.weekday < WEEKDAY_LAST)
							cal_d.weekday = cal_q.weekday + 3'd1;
						else
							cal_d.weekday = '0;
						clr = ~item.trip_running;
					end
				end
			end
			OP_SET_TIME: begin
				// hour is stored even if the minute is then rejected
				if (item.hour_value < HOUR_LIMIT) begin
					cal_d.hour = item.hour_value[4:0];
					if (item.minute_value < MINUTE_LIMIT)
						cal_d.minute = item.minute_value[5:0];
					else
						acc = 1'b0;
				end else begin
					acc = 1'b0;
				end
			end
			OP_SET_DATE: begin
				cal_d.day   = item.day_value;
				cal_d.month = item.month_value;
				cal_d.year  = item.year_value;
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.minute  <= MINUTE_RESET;
			cal_q.hour    <= HOUR_RESET;
			cal_q.day     <= DAY_RESET;
			cal_q.month   <= MONTH_RESET;
			cal_q.year    <= YEAR_RESET;
			cal_q.weekday <= WEEKDAY_RESET;
		end else if (step) begin
			cal_q <= cal_d;
		end
	end

	always_comb begin
		result.minute_now  = cal_d.minute;
		result.hour_now    = cal_d.hour;
		result.day_now     = cal_d.day;
		result.month_now   = cal_d.month;
		result.year_now    = cal_d.year;
		result.weekday_now = cal_d.weekday;
		result.accepted    = acc;
		result.clear_trip  = clr;
	end

endmodule

[design/mtcc_result_reg.sv]
module mtcc_result_reg
	import mtcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t result,
	output logic busy,
	mtcc_chan_if.source rsp
);

	logic valid_q;
	rsp_t data_q;

	// full and not being drained this cycle
	assign busy = valid_q & ~rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= result;
	end

	assign rsp.valid = valid_q;
	assign rsp.data  = data_q;

endmodule

[design/minute_tick_calendar_clock_unit.sv]
// Minute-resolution calendar clock.
//
// Channels: req carries one operation item (minute tick, set time, set
// date) with its operands; rsp carries one result item per request: the
// calendar after the operation, the accept flag and the trip-clear pulse.
// Both use valid/ready; an item moves on an edge where both are high.
//
// An accepted item waits in the input register; at the edge where the
// result register can take it, its update is applied and its result
// captured, driving rsp.valid. Throughput is one item per cycle unless
// rsp stalls; the calendar registers are the only feedback.
//
// Reset (arst_n low) puts the clock at 00:00, day 1, month 1, year 2001,
// weekday 0 and empties both registers.
//
// When the receiver stalls, the result register holds its item and the
// input register takes one more item; after that req.ready drops until
// rsp drains. Nothing is dropped or repeated.
module minute_tick_calendar_clock_unit
	import mtcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mtcc_chan_if.sink   req,
	mtcc_chan_if.source rsp
);

	logic valid_s1;
	req_t item_s1;
	logic out_busy;
	logic step;
	rsp_t result;

	// advance the input stage whenever the result register can take it
	assign step      = valid_s1 & ~out_busy;
	assign req.ready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			item_s1 <= req.data;
	end

	// calendar state and its next-value logic
	mtcc_timekeeper u_keeper (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	// result register toward the receiver
	mtcc_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.result (result),
		.busy   (out_busy),
		.rsp    (rsp)
	);

	// a blocked item stays in the input stage unchanged
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled item");

	// a trip-clear only comes from a midnight rollover
	a_clear_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.clear_trip |->
			rsp.data.minute_now == 6'd0 && rsp.data.hour_now == 5'd0 &&
			rsp.data.accepted)
		else $error("clear_trip outside a day rollover");

	// the weekday never reaches seven
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.weekday_now != 3'd7)
		else $error("weekday out of range");

	// a loaded result stays visible until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");

endmodule
